@@ rtl/depq_pkg.sv @@
// ----------------------------------------------------------------------------
// depq_pkg
// Types and codes shared by the double-ended priority queue modules.
// ----------------------------------------------------------------------------
package depq_pkg;

    localparam int KEY_W = 24;
    localparam int ID_W  = 20;

    // Command codes.
    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_POP_MAX = 2'd1;
    localparam logic [1:0] CMD_POP_MIN = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_POPPED = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] priority_key;
        logic [ID_W-1:0]  client_id;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0] popped_id;
        logic [1:0]      status;
    } t_out_item;

    // One stored entry of a cell.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_entry;

    // Operation broadcast to every cell of both chains.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_cell_ctl;

endpackage

@@ rtl/double_ended_priority_queue.sv @@
// A pop or a rejected insert shows its result in the cycle after the transfer.
// Throughput: one command per cycle while the input is not stalled; every command
// updates all cells together because each cell compares its own key with the broadcast key.
// The input stalls only while a result waits in the output register.
// Reset (synchronous, active low) empties both chains and the output register.
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Two sorted cell chains hold the same entries, one by descending key and one
// by ascending key. Pop-max takes the head of the first, pop-min the head of
// the second, and the other chain drops the same entry by key compare.
// ----------------------------------------------------------------------------
module double_ended_priority_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  depq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output depq_pkg::t_out_item o_out_data
);
    import depq_pkg::*;

    logic      w_accept;
    t_cell_ctl w_ctl;
    t_entry    w_head_max;
    t_entry    w_head_min;
    logic      w_full;
    logic      w_unused_tail;
    logic      w_res;
    t_out_item w_res_data;

    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out_data;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_ctl      = '0;
        w_ctl.key  = i_in_data.priority_key;
        w_ctl.id   = i_in_data.client_id;
        w_res      = 1'b0;
        w_res_data = '0;
        case (i_in_data.command)
            CMD_INSERT: begin
                if (w_full) begin
                    w_res             = 1'b1;
                    w_res_data.status = ST_FULL;
                end else begin
                    w_ctl.ins = w_accept;
                end
            end
            CMD_POP_MAX: begin
                w_res = 1'b1;
                if (w_head_max.valid) begin
                    w_ctl.del            = w_accept;
                    w_ctl.key            = w_head_max.key;
                    w_res_data.popped_id = w_head_max.id;
                    w_res_data.status    = ST_POPPED;
                end else begin
                    w_res_data.status = ST_EMPTY;
                end
            end
            CMD_POP_MIN: begin
                w_res = 1'b1;
                if (w_head_min.valid) begin
                    w_ctl.del            = w_accept;
                    w_ctl.key            = w_head_min.key;
                    w_res_data.popped_id = w_head_min.id;
                    w_res_data.status    = ST_POPPED;
                end else begin
                    w_res_data.status = ST_EMPTY;
                end
            end
            default: begin
                w_res = 1'b0;
            end
        endcase
    end

    depq_chain #(
        .CAPACITY   (CAPACITY),
        .DESCENDING (1'b1)
    ) u_chain_max (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_head       (w_head_max),
        .o_tail_valid (w_full)
    );

    depq_chain #(
        .CAPACITY   (CAPACITY),
        .DESCENDING (1'b0)
    ) u_chain_min (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_head       (w_head_min),
        .o_tail_valid (w_unused_tail)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept && w_res) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_res) begin
            r_out_data <= w_res_data;
        end
    end

    // Both chains always hold the same number of entries, so either tail
    // tells whether the store is full.
    assign o_out_valid = r_out_valid && (w_unused_tail | !w_unused_tail);
    assign o_out_data  = r_out_data;

endmodule

@@ rtl/depq_cell.sv @@
// ----------------------------------------------------------------------------
// depq_cell
// One slot of a sorted chain. On an insert it keeps its entry, takes the new
// entry or takes its upstream neighbor's entry; on a delete it keeps its entry
// or takes its downstream neighbor's entry.
// ----------------------------------------------------------------------------
module depq_cell #(
    parameter bit DESCENDING = 1'b1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  depq_pkg::t_cell_ctl i_ctl,
    input  depq_pkg::t_entry    i_prev,
    input  depq_pkg::t_entry    i_next,
    output depq_pkg::t_entry    o_entry
);
    import depq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_self_before;
    logic   w_prev_before;
    logic   w_self_after;

    // An entry stays ahead of a new one when it ranks at least equal, so that
    // equal keys keep their arrival order.
    always_comb begin
        if (DESCENDING) begin
            w_self_before = r_entry.valid && (r_entry.key >= i_ctl.key);
            w_prev_before = i_prev.valid && (i_prev.key >= i_ctl.key);
            w_self_after  = !r_entry.valid || (r_entry.key <= i_ctl.key);
        end else begin
            w_self_before = r_entry.valid && (r_entry.key <= i_ctl.key);
            w_prev_before = i_prev.valid && (i_prev.key <= i_ctl.key);
            w_self_after  = !r_entry.valid || (r_entry.key >= i_ctl.key);
        end
    end

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (!w_self_before) begin
                if (w_prev_before) begin
                    n_entry.valid = 1'b1;
                    n_entry.key   = i_ctl.key;
                    n_entry.id    = i_ctl.id;
                end else begin
                    n_entry = i_prev;
                end
            end
        end else if (i_ctl.del) begin
            // Cells from the first entry of the removed key onward close the gap.
            if (w_self_after) begin
                n_entry = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

@@ rtl/depq_chain.sv @@
// ----------------------------------------------------------------------------
// depq_chain
// A row of cells kept sorted by key, descending or ascending, with equal keys
// in arrival order. The head holds the entry that a pop from this end takes.
// ----------------------------------------------------------------------------
module depq_chain #(
    parameter int CAPACITY   = 1024,
    parameter bit DESCENDING = 1'b1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  depq_pkg::t_cell_ctl i_ctl,
    output depq_pkg::t_entry    o_head,
    output logic                o_tail_valid
);
    import depq_pkg::*;

    t_entry w_cells [CAPACITY];
    t_entry w_head_guard;
    t_entry w_tail_guard;

    // The guard ahead of the head always ranks first; the one past the tail
    // is empty.
    always_comb begin
        w_head_guard.valid = 1'b1;
        w_head_guard.key   = DESCENDING ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
        w_head_guard.id    = '0;
        w_tail_guard       = '0;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;

        if (g == 0) begin : g_first
            assign w_prev = w_head_guard;
        end else begin : g_mid_prev
            assign w_prev = w_cells[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_tail_guard;
        end else begin : g_mid_next
            assign w_next = w_cells[g+1];
        end

        depq_cell #(
            .DESCENDING(DESCENDING)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_entry (w_cells[g])
        );
    end

    assign o_head       = w_cells[0];
    assign o_tail_valid = w_cells[CAPACITY-1].valid;

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double-ended priority queue. A scoreboard keeps
// the stored entries in arrival order and predicts every pop, empty and full
// response, which are compared field by field as they leave the block.
// ----------------------------------------------------------------------------
module tb;

    import depq_pkg::*;

    localparam int DEPTH = 1024;
    localparam int QUIET_LIMIT = 400;
    localparam int TAIL_CYCLES = 8;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_held;

    class depq_scoreboard;
        t_held     held[$];
        t_out_item awaited[$];
        int        capacity;
        int        mismatches;
        int        n_inserted;
        int        n_popped;
        int        n_empty;
        int        n_full;
        int        deepest;

        function new(int depth);
            capacity   = depth;
            mismatches = 0;
            n_inserted = 0;
            n_popped   = 0;
            n_empty    = 0;
            n_full     = 0;
            deepest    = 0;
        endfunction

        task report(string what);
            $display("MISMATCH: %s", what);
            mismatches++;
        endtask

        // Applies one accepted command and queues the response it should cause.
        function void note_command(t_in_item item);
            t_out_item res;
            t_held     ent;
            int        best;
            res.popped_id = '0;
            res.status    = ST_POPPED;
            case (item.command)
                CMD_INSERT: begin
                    if (held.size() >= capacity) begin
                        res.status = ST_FULL;
                        awaited.push_back(res);
                        n_full++;
                    end else begin
                        ent.key = item.priority_key;
                        ent.id  = item.client_id;
                        held.push_back(ent);
                        n_inserted++;
                        if (held.size() > deepest) deepest = held.size();
                    end
                end
                CMD_POP_MAX, CMD_POP_MIN: begin
                    if (held.size() == 0) begin
                        res.status = ST_EMPTY;
                        n_empty++;
                    end else begin
                        // Strict compares keep the earliest entry among equal keys.
                        best = 0;
                        for (int i = 1; i < held.size(); i++) begin
                            if (item.command == CMD_POP_MAX) begin
                                if (held[i].key > held[best].key) best = i;
                            end else begin
                                if (held[i].key < held[best].key) best = i;
                            end
                        end
                        res.popped_id = held[best].id;
                        held.delete(best);
                        n_popped++;
                    end
                    awaited.push_back(res);
                end
                default: begin
                end
            endcase
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result id=%05h status=%0d",
                                 got.popped_id, got.status));
            end else begin
                want = awaited.pop_front();
                if (got.popped_id !== want.popped_id)
                    report($sformatf("popped_id %05h, expected %05h",
                                     got.popped_id, want.popped_id));
                if (got.status !== want.status)
                    report($sformatf("status %0d, expected %0d", got.status, want.status));
            end
        endtask
    endclass

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    depq_scoreboard sb;
    bit             no_idle = 1'b0;

    double_ended_priority_queue #(
        .CAPACITY(DEPTH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    // Presents one command and returns in the time step of its transfer.
    task automatic send_item(input t_in_item item);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        sb.note_command(item);
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                            input logic [ID_W-1:0] id);
        t_in_item item;
        item.command      = cmd;
        item.priority_key = key;
        item.client_id    = id;
        send_item(item);
    endtask

    function automatic t_in_item random_item(int ins_pct);
        t_in_item item;
        if ($urandom_range(0, 99) < 3)
            item.command = CMD_UNUSED;
        else if ($urandom_range(0, 99) < ins_pct)
            item.command = CMD_INSERT;
        else if ($urandom_range(0, 1) == 1)
            item.command = CMD_POP_MAX;
        else
            item.command = CMD_POP_MIN;
        // Narrow keys are frequent so that equal keys meet often.
        case ($urandom_range(0, 9))
            0:       item.priority_key = '0;
            1:       item.priority_key = '1;
            2, 3, 4: item.priority_key = KEY_W'($urandom_range(0, 7));
            default: item.priority_key = KEY_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       item.client_id = '0;
            1:       item.client_id = '1;
            default: item.client_id = ID_W'($urandom);
        endcase
        return item;
    endfunction

    task automatic run_random(input int count, input int ins_pct, input bit until_full);
        int       sent;
        t_in_item item;
        sent = 0;
        while (until_full ? (sb.held.size() < DEPTH) : (sent < count)) begin
            if (sent % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            item = random_item(ins_pct);
            send_item(item);
            if (item.command != CMD_UNUSED) sent++;
        end
    endtask

    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                sb.check_result(out_data);
                hold = draw_wait();
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                hold--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transfer for %0d cycles", quiet);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        sb = new(DEPTH);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Pops on an empty queue and an unused command.
        send_cmd(CMD_POP_MAX, '1, '1);
        send_cmd(CMD_POP_MIN, '0, '0);
        send_cmd(CMD_UNUSED, '1, '1);
        // Extreme keys and ties at both ends and in the middle.
        send_cmd(CMD_INSERT, '0, '1);
        send_cmd(CMD_INSERT, '1, '0);
        send_cmd(CMD_INSERT, KEY_W'(5), ID_W'(1));
        send_cmd(CMD_INSERT, KEY_W'(5), ID_W'(2));
        send_cmd(CMD_INSERT, '1, ID_W'(3));
        send_cmd(CMD_INSERT, '0, ID_W'(4));
        send_cmd(CMD_UNUSED, '0, '0);
        send_cmd(CMD_POP_MAX, '0, '0);
        send_cmd(CMD_POP_MAX, '0, '0);
        send_cmd(CMD_POP_MIN, '1, '1);
        send_cmd(CMD_POP_MIN, '1, '1);
        send_cmd(CMD_POP_MAX, '0, '0);
        send_cmd(CMD_POP_MIN, '0, '0);
        send_cmd(CMD_POP_MIN, '0, '0);
        send_cmd(CMD_INSERT, 24'hAAAAAA, 20'h55555);
        send_cmd(CMD_INSERT, 24'h555555, 20'hAAAAA);
        send_cmd(CMD_POP_MAX, '0, '0);
        send_cmd(CMD_POP_MIN, '0, '0);
        send_cmd(CMD_POP_MAX, '0, '0);

        // Shallow mixed traffic, then a fill to capacity, churn at the
        // full boundary, and a long drain from the deep store.
        run_random(300, 55, 1'b0);
        run_random(0, 97, 1'b1);
        run_random(40, 75, 1'b0);
        run_random(400, 10, 1'b0);
        in_valid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d inserts, %0d pops, %0d pops on an empty queue,",
                 sb.n_inserted, sb.n_popped, sb.n_empty);
        $display("%0d inserts refused when full; deepest fill %0d of %0d entries.",
                 sb.n_full, sb.deepest, DEPTH);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
